@@ hdl/gsf_pkg.sv @@
// Shared types and constants for the grasp sequencer.
package gsf_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_ESTOP   = 2'd1,
    OP_REQUEST = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SCAN_TO     = 3'd0,
    REG_ANALYZE_TO  = 3'd1,
    REG_TAP_TO      = 3'd2,
    REG_PLAN_TO     = 3'd3,
    REG_APPROACH_TO = 3'd4,
    REG_GRIP_TO     = 3'd5,
    REG_PROCEED_TH  = 3'd6,
    REG_NONE        = 3'd7
  } cfg_idx_e;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned TO_W    = 16;
  localparam int unsigned Q8_W    = 9;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned FORCE_W = 16;

  // Configuration reset values
  localparam logic [TO_W-1:0] SCAN_TO_RST     = 16'd3000;
  localparam logic [TO_W-1:0] ANALYZE_TO_RST  = 16'd2000;
  localparam logic [TO_W-1:0] TAP_TO_RST      = 16'd1500;
  localparam logic [TO_W-1:0] PLAN_TO_RST     = 16'd1000;
  localparam logic [TO_W-1:0] APPROACH_TO_RST = 16'd5000;
  localparam logic [TO_W-1:0] GRIP_TO_RST     = 16'd3000;
  localparam logic [Q8_W-1:0] PROCEED_TH_RST  = 9'd128;

  // Fixed thresholds
  localparam logic [DIST_W-1:0]  DETECT_NEAR_MM   = 16'd300;
  localparam logic [DIST_W-1:0]  SCAN_NEAR_MM     = 16'd200;
  localparam logic [DIST_W-1:0]  LOST_FAR_MM      = 16'd500;
  localparam logic [TIME_W-1:0]  DETECT_LIMIT_MS  = 32'd5000;
  localparam logic [TIME_W-1:0]  RELEASE_LIMIT_MS = 32'd3000;
  localparam logic [TIME_W-1:0]  ERROR_LIMIT_MS   = 32'd2000;
  localparam logic [FORCE_W-1:0] FORCE_APPROACH   = 16'd20;  // 0.2 N
  localparam logic [FORCE_W-1:0] FORCE_HOLD_MIN   = 16'd50;  // 0.5 N
  localparam logic [FORCE_W-1:0] FORCE_LOST       = 16'd10;  // 0.1 N
  localparam logic [FORCE_W-1:0] FORCE_RELEASED   = 16'd5;   // 0.05 N
  localparam logic [11:0]        PLAN_Q_LIMIT     = 12'd256; // 5*q > 256 is q > 0.2
  localparam logic [13:0]        HOLD_Q_LIMIT     = 14'd768; // 20*q < 768 is q < 0.15

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 8;

  typedef struct packed {
    logic [Q8_W-1:0]    hold_quality;
    logic [Q8_W-1:0]    plan_quality;
    logic [Q8_W-1:0]    grasp_odds;
    logic [FORCE_W-1:0] target_force;
    logic               plan_ok;
    logic               slip_seen;
    logic [FORCE_W-1:0] total_force;
    logic [DIST_W-1:0]  nearest_depth_mm;
    logic [3:0]         valid_mask;
    logic [STATE_W-1:0] requested_state;
    logic [TIME_W-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic [TO_W-1:0] scan_to;
    logic [TO_W-1:0] analyze_to;
    logic [TO_W-1:0] tap_to;
    logic [TO_W-1:0] plan_to;
    logic [TO_W-1:0] approach_to;
    logic [TO_W-1:0] grip_to;
    logic [Q8_W-1:0] proceed_th;
  } cfg_t;

  typedef struct packed {
    logic               entered;
    logic [STATE_W-1:0] state;
  } result_t;

endpackage

@@ hdl/gsf_core.sv @@
// Sequencer state, pending stop/request latches and the per-item transition logic.
module gsf_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  gsf_pkg::opcode_e      op_i,
  input  gsf_pkg::item_t        item_i,
  input  gsf_pkg::cfg_t         cfg_i,
  output gsf_pkg::result_t      res_o
);

  typedef enum logic [gsf_pkg::STATE_W-1:0] {
    ST_IDLE        = 4'd0,
    ST_DETECTED    = 4'd1,
    ST_SCANNING    = 4'd2,
    ST_ANALYZING   = 4'd3,
    ST_TAP         = 4'd4,
    ST_CLASSIFYING = 4'd5,
    ST_PLANNING    = 4'd6,
    ST_APPROACHING = 4'd7,
    ST_GRIPPING    = 4'd8,
    ST_HOLDING     = 4'd9,
    ST_RELEASING   = 4'd10,
    ST_ERROR       = 4'd11
  } state_e;

  state_e                           state_q, state_d;
  logic [gsf_pkg::TIME_W-1:0]       entry_q, entry_d;
  logic                             stop_q, stop_d;
  logic                             req_q, req_d;
  logic [gsf_pkg::STATE_W-1:0]      tgt_q, tgt_d;

  logic [gsf_pkg::TIME_W-1:0]       elapsed;
  logic                             dv, cv, iv, fv;
  logic [19:0]                      force_x10, tforce_x9;
  logic [11:0]                      pq_x5;
  logic [13:0]                      hq_x20;
  logic                             go;
  state_e                           go_st;
  logic                             served;

  function automatic logic past_limit(input logic [gsf_pkg::TIME_W-1:0] el,
                                      input logic [gsf_pkg::TO_W-1:0]   lim);
    return el > {{(gsf_pkg::TIME_W-gsf_pkg::TO_W){1'b0}}, lim};
  endfunction

  // Sensor flags and scaled comparisons
  assign dv        = item_i.valid_mask[0];
  assign cv        = item_i.valid_mask[1];
  assign iv        = item_i.valid_mask[2];
  assign fv        = item_i.valid_mask[3];
  assign elapsed   = item_i.now_ms - entry_q;
  assign force_x10 = {1'b0, item_i.total_force, 3'b000} + {3'b000, item_i.total_force, 1'b0};
  assign tforce_x9 = {1'b0, item_i.target_force, 3'b000} + {4'b0000, item_i.target_force};
  assign pq_x5     = {1'b0, item_i.plan_quality, 2'b00} + {3'b000, item_i.plan_quality};
  assign hq_x20    = {1'b0, item_i.hold_quality, 4'b0000} + {3'b000, item_i.hold_quality, 2'b00};

  // Transition rules: later rules in a state override earlier ones
  always_comb begin
    go     = 1'b0;
    go_st  = state_q;
    served = 1'b0;
    stop_d = stop_q;
    req_d  = req_q;
    tgt_d  = tgt_q;
    if (fire_i) begin
      unique case (op_i)
        gsf_pkg::OP_STEP: begin
          if (stop_q) begin
            stop_d = 1'b0;
            go     = 1'b1;
            go_st  = ST_RELEASING;
          end else begin
            if (req_q) begin
              req_d = 1'b0;
              if (tgt_q == ST_IDLE) begin
                go     = 1'b1;
                go_st  = ST_IDLE;
                served = 1'b1;
              end else if (tgt_q == ST_RELEASING) begin
                go     = 1'b1;
                go_st  = ST_RELEASING;
                served = 1'b1;
              end else if (tgt_q == ST_DETECTED && state_q == ST_IDLE) begin
                go     = 1'b1;
                go_st  = ST_DETECTED;
                served = 1'b1;
              end
            end
            if (!served) begin
              unique case (state_q)
                ST_IDLE: begin
                  if (dv && item_i.nearest_depth_mm < gsf_pkg::DETECT_NEAR_MM) begin
                    go = 1'b1; go_st = ST_DETECTED;
                  end
                end
                ST_DETECTED: begin
                  if (dv && item_i.nearest_depth_mm < gsf_pkg::SCAN_NEAR_MM) begin
                    go = 1'b1; go_st = ST_SCANNING;
                  end else if (dv && item_i.nearest_depth_mm > gsf_pkg::LOST_FAR_MM) begin
                    go = 1'b1; go_st = ST_IDLE;
                  end
                  if (elapsed > gsf_pkg::DETECT_LIMIT_MS) begin
                    go = 1'b1; go_st = ST_IDLE;
                  end
                end
                ST_SCANNING: begin
                  if ((cv && dv) || past_limit(elapsed, cfg_i.scan_to)) begin
                    go = 1'b1; go_st = ST_ANALYZING;
                  end
                end
                ST_ANALYZING: begin
                  if (iv || past_limit(elapsed, cfg_i.analyze_to)) begin
                    go = 1'b1; go_st = ST_TAP;
                  end
                end
                ST_TAP: begin
                  if (past_limit(elapsed, cfg_i.tap_to)) begin
                    go = 1'b1; go_st = ST_CLASSIFYING;
                  end
                end
                ST_CLASSIFYING: begin
                  go = 1'b1; go_st = ST_PLANNING;
                end
                ST_PLANNING: begin
                  if (item_i.plan_ok) begin
                    go    = 1'b1;
                    go_st = (item_i.grasp_odds >= cfg_i.proceed_th) ? ST_APPROACHING
                                                                    : ST_ERROR;
                  end
                  if (past_limit(elapsed, cfg_i.plan_to)) begin
                    go    = 1'b1;
                    go_st = (pq_x5 > gsf_pkg::PLAN_Q_LIMIT) ? ST_APPROACHING : ST_ERROR;
                  end
                end
                ST_APPROACHING: begin
                  if (fv && item_i.total_force > gsf_pkg::FORCE_APPROACH) begin
                    go = 1'b1; go_st = ST_GRIPPING;
                  end
                  if (past_limit(elapsed, cfg_i.approach_to)) begin
                    go = 1'b1; go_st = ST_ERROR;
                  end
                end
                ST_GRIPPING: begin
                  if (fv && force_x10 >= tforce_x9) begin
                    go = 1'b1; go_st = ST_HOLDING;
                  end
                  if (past_limit(elapsed, cfg_i.grip_to)) begin
                    go    = 1'b1;
                    go_st = (fv && item_i.total_force > gsf_pkg::FORCE_HOLD_MIN) ? ST_HOLDING
                                                                                : ST_ERROR;
                  end
                end
                ST_HOLDING: begin
                  if (fv && (item_i.total_force < gsf_pkg::FORCE_LOST ||
                             (item_i.slip_seen && hq_x20 < gsf_pkg::HOLD_Q_LIMIT))) begin
                    go = 1'b1; go_st = ST_ERROR;
                  end
                end
                ST_RELEASING: begin
                  if ((fv && item_i.total_force < gsf_pkg::FORCE_RELEASED) ||
                      elapsed > gsf_pkg::RELEASE_LIMIT_MS) begin
                    go = 1'b1; go_st = ST_IDLE;
                  end
                end
                ST_ERROR: begin
                  if (elapsed > gsf_pkg::ERROR_LIMIT_MS) begin
                    go = 1'b1; go_st = ST_IDLE;
                  end
                end
                default: begin
                  go = 1'b0;
                end
              endcase
            end
          end
        end
        gsf_pkg::OP_ESTOP: begin
          stop_d = 1'b1;
        end
        gsf_pkg::OP_REQUEST: begin
          req_d = 1'b1;
          tgt_d = item_i.requested_state;
        end
        default: begin
          stop_d = stop_q;
        end
      endcase
    end
    state_d = go ? go_st : state_q;
    entry_d = go ? item_i.now_ms : entry_q;
  end

  assign res_o.state   = state_d;
  assign res_o.entered = go;

  // State and latches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      entry_q <= '0;
      stop_q  <= 1'b0;
      req_q   <= 1'b0;
      tgt_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      entry_q <= entry_d;
      stop_q  <= stop_d;
      req_q   <= req_d;
      tgt_q   <= tgt_d;
    end
  end

  // A pending stop always wins on the next step
  a_stop_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && op_i == gsf_pkg::OP_STEP && stop_q |=> state_q == ST_RELEASING && !stop_q)
    else $error("pending stop not served as release");

  // Latching items never cause a state entry
  a_latch_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && op_i != gsf_pkg::OP_STEP |-> !go)
    else $error("state entry on a non-step item");

  // Entry time only moves with a state entry
  a_entry_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go |=> $stable(entry_q))
    else $error("entry time changed without a state entry");

  // A step without a pending stop consumes the pending request
  a_req_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && op_i == gsf_pkg::OP_STEP && !stop_q |=> !req_q)
    else $error("request still pending after a step");

endmodule

@@ hdl/grasp_sequencer_fsm_top.sv @@
// Top level of the grasp sequencer: stream ports, input register, result register, config.
// The grasp sequencer takes one item per clock cycle on the slave stream while the master keeps
// up, and gives one result per item on the master stream, in order. An item waits in the input
// register, where the transition logic runs against the sequencer state, until the result
// register is free; its result is then captured in the result register and offered from there.
// A stalled master only holds the input side once both registers are full. Configuration
// writes are registered and are always accepted.
module grasp_sequencer_fsm_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, low to high: now_ms[31:0], requested_state[35:32], valid_mask[39:36],
  // nearest_depth_mm[55:40], total_force[71:56], slip_seen[72], plan_ok[73],
  // target_force[89:74], grasp_odds[98:90], plan_quality[107:99],
  // hold_quality[116:108], zero pad[119:117]
  input  logic [gsf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]                        s_axis_tuser,
  // Results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, low to high: current_state[3:0], state_entered[4], zero pad[7:5]
  output logic [gsf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [gsf_pkg::TO_W-1:0]          cfg_data_i
);

  logic                  in_valid_q;
  gsf_pkg::item_t        in_item_q;
  gsf_pkg::opcode_e      in_op_q;
  logic                  out_valid_q;
  gsf_pkg::result_t      out_res_q;
  gsf_pkg::result_t      core_res;
  gsf_pkg::cfg_t         cfg_q;
  logic                  advance;
  gsf_pkg::cfg_idx_e     cfg_idx;

  // Handshake: move the held item through when the result register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(gsf_pkg::OUT_DATA_W-gsf_pkg::STATE_W-1){1'b0}},
                          out_res_q.entered, out_res_q.state};
  assign cfg_ready_o   = 1'b1;
  assign cfg_idx       = gsf_pkg::cfg_idx_e'(cfg_index_i);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= gsf_pkg::item_t'(s_axis_tdata[$bits(gsf_pkg::item_t)-1:0]);
      in_op_q   <= gsf_pkg::opcode_e'(s_axis_tuser);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_to     <= gsf_pkg::SCAN_TO_RST;
      cfg_q.analyze_to  <= gsf_pkg::ANALYZE_TO_RST;
      cfg_q.tap_to      <= gsf_pkg::TAP_TO_RST;
      cfg_q.plan_to     <= gsf_pkg::PLAN_TO_RST;
      cfg_q.approach_to <= gsf_pkg::APPROACH_TO_RST;
      cfg_q.grip_to     <= gsf_pkg::GRIP_TO_RST;
      cfg_q.proceed_th  <= gsf_pkg::PROCEED_TH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx)
        gsf_pkg::REG_SCAN_TO:     cfg_q.scan_to     <= cfg_data_i;
        gsf_pkg::REG_ANALYZE_TO:  cfg_q.analyze_to  <= cfg_data_i;
        gsf_pkg::REG_TAP_TO:      cfg_q.tap_to      <= cfg_data_i;
        gsf_pkg::REG_PLAN_TO:     cfg_q.plan_to     <= cfg_data_i;
        gsf_pkg::REG_APPROACH_TO: cfg_q.approach_to <= cfg_data_i;
        gsf_pkg::REG_GRIP_TO:     cfg_q.grip_to     <= cfg_data_i;
        gsf_pkg::REG_PROCEED_TH:  cfg_q.proceed_th  <= cfg_data_i[gsf_pkg::Q8_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  gsf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .op_i   (in_op_q),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (core_res)
  );

  // A processed item always lands in the result register
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item did not reach the result register");

  // Input stalls only when both registers are full and the master holds off
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without a full pipeline");

  // A held result is not overwritten while the master stalls
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(out_res_q))
    else $error("result overwritten under stall");

endmodule
